[rtl/tsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TGA stream parser package
// Shared types and constants for the TGA stream parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int HEADER_BYTES = 18;
    localparam int HDR_IDX_W    = 5;
    localparam int COUNT_W      = 34;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_ID_LEN     = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE       = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_CMAP_LEN_L = 5'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_CMAP_LEN_H = 5'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_CMAP_DEPTH = 5'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_L    = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_H    = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_L   = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_H   = 5'd15;
    localparam logic [HDR_IDX_W-1:0] HDR_DEPTH      = 5'd16;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST       = HDR_IDX_W'(HEADER_BYTES - 1);

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_24       = 8'd24;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE  = 3'd2;
    localparam logic [2:0] ST_WRONG_DEPTH = 3'd3;
    localparam logic [2:0] ST_SHORT_ID    = 3'd4;
    localparam logic [2:0] ST_SHORT_CMAP  = 3'd5;
    localparam logic [2:0] ST_SHORT_IMAGE = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel;
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

[rtl/tga_stream_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TGA stream parser
// Reads an uncompressed 24-bit TGA file as a byte stream and passes the
// pixel bytes through, reporting completion and errors.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                      tuser         tlast
// s         in   [7:0] file byte            -             end of file
// m         out  pixel/status/width/height  result kind   last of image
//
// One input word per cycle while tready is high; results enter the output stage.
// Header sizes (w*h, colour map) are registered products ready by the last
// header byte. A two-entry output stage (register + skid) decouples the sides;
// tready drops only when both entries are full. Reset is synchronous, active
// low, and returns the parser to the header phase.
// ----------------------------------------------------------------------------
module tga_stream_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tlast,   // end_marker
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // [7:0] pixel_byte, [10:8] status_code,
                                     // [26:11] image_width, [42:27] image_height
    output logic [1:0]  o_m_tuser,   // [1:0] result_kind
    output logic        o_m_tlast    // last_flag
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_CMAP   = 3'd2;
    localparam logic [2:0] PH_IMAGE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam int CW = tsp_pkg::COUNT_W;

    logic [2:0]                    r_phase, n_phase;
    logic [tsp_pkg::HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [CW-1:0]                 r_count, n_count;

    logic [7:0]  r_id_len;
    logic [7:0]  r_type;
    logic [15:0] r_cmap_len;
    logic [4:0]  r_cmap_depth;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [7:0]  r_depth;
    logic [31:0] r_area;
    logic [20:0] r_cmap_size;

    logic            accept;
    logic            res_valid;
    tsp_pkg::t_result res;
    tsp_pkg::t_result out_data;
    logic [CW-1:0]   img_size;
    logic [CW-1:0]   count_dec;
    logic            count_one;

    assign accept    = i_s_tvalid && o_s_tready;
    assign img_size  = {2'b00, r_area} + {1'b0, r_area, 1'b0};
    assign count_dec = r_count - CW'(1);
    assign count_one = (r_count == CW'(1));

    always_ff @(posedge i_clk) begin
        r_area      <= {16'd0, r_width} * {16'd0, r_height};
        r_cmap_size <= {5'd0, r_cmap_len} * {16'd0, r_cmap_depth};
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_s_tlast && r_phase == PH_HEADER) begin
            unique case (r_hdr_idx)
                tsp_pkg::HDR_ID_LEN:     r_id_len          <= i_s_tdata;
                tsp_pkg::HDR_TYPE:       r_type            <= i_s_tdata;
                tsp_pkg::HDR_CMAP_LEN_L: r_cmap_len[7:0]   <= i_s_tdata;
                tsp_pkg::HDR_CMAP_LEN_H: r_cmap_len[15:8]  <= i_s_tdata;
                tsp_pkg::HDR_CMAP_DEPTH: r_cmap_depth      <= i_s_tdata[7:3];
                tsp_pkg::HDR_WIDTH_L:    r_width[7:0]      <= i_s_tdata;
                tsp_pkg::HDR_WIDTH_H:    r_width[15:8]     <= i_s_tdata;
                tsp_pkg::HDR_HEIGHT_L:   r_height[7:0]     <= i_s_tdata;
                tsp_pkg::HDR_HEIGHT_H:   r_height[15:8]    <= i_s_tdata;
                tsp_pkg::HDR_DEPTH:      r_depth           <= i_s_tdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_count    = r_count;
        res_valid  = 1'b0;
        res.kind   = tsp_pkg::KIND_PIXEL;
        res.pixel  = 8'd0;
        res.status = tsp_pkg::ST_OK;
        res.width  = r_width;
        res.height = r_height;
        res.last   = 1'b0;
        if (accept) begin
            if (i_s_tlast) begin
                n_phase   = PH_HEADER;
                n_hdr_idx = '0;
                n_count   = '0;
                res.kind  = tsp_pkg::KIND_ERROR;
                res.last  = 1'b1;
                unique case (r_phase)
                    PH_HEADER: begin
                        res_valid  = 1'b1;
                        res.status = tsp_pkg::ST_SHORT_HDR;
                        res.width  = 16'd0;
                        res.height = 16'd0;
                    end
                    PH_ID: begin
                        res_valid  = 1'b1;
                        res.status = tsp_pkg::ST_SHORT_ID;
                    end
                    PH_CMAP: begin
                        res_valid  = 1'b1;
                        res.status = tsp_pkg::ST_SHORT_CMAP;
                    end
                    PH_IMAGE: begin
                        res_valid  = 1'b1;
                        res.status = tsp_pkg::ST_SHORT_IMAGE;
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_hdr_idx == tsp_pkg::HDR_LAST) begin
                            n_hdr_idx = '0;
                            if (r_type != tsp_pkg::TYPE_TRUECOLOR) begin
                                n_phase    = PH_DONE;
                                res_valid  = 1'b1;
                                res.kind   = tsp_pkg::KIND_ERROR;
                                res.status = tsp_pkg::ST_WRONG_TYPE;
                                res.last   = 1'b1;
                            end else if (r_depth != tsp_pkg::DEPTH_24) begin
                                n_phase    = PH_DONE;
                                res_valid  = 1'b1;
                                res.kind   = tsp_pkg::KIND_ERROR;
                                res.status = tsp_pkg::ST_WRONG_DEPTH;
                                res.last   = 1'b1;
                            end else if (r_id_len != 8'd0) begin
                                n_phase = PH_ID;
                                n_count = CW'(r_id_len);
                            end else if (r_cmap_size != 21'd0) begin
                                n_phase = PH_CMAP;
                                n_count = CW'(r_cmap_size);
                            end else if (img_size != '0) begin
                                n_phase = PH_IMAGE;
                                n_count = img_size;
                            end else begin
                                n_phase   = PH_DONE;
                                res_valid = 1'b1;
                                res.kind  = tsp_pkg::KIND_DONE;
                                res.last  = 1'b1;
                            end
                        end else begin
                            n_hdr_idx = r_hdr_idx + 5'd1;
                        end
                    end
                    PH_ID: begin
                        if (!count_one) begin
                            n_count = count_dec;
                        end else if (r_cmap_size != 21'd0) begin
                            n_phase = PH_CMAP;
                            n_count = CW'(r_cmap_size);
                        end else if (img_size != '0) begin
                            n_phase = PH_IMAGE;
                            n_count = img_size;
                        end else begin
                            n_phase   = PH_DONE;
                            n_count   = '0;
                            res_valid = 1'b1;
                            res.kind  = tsp_pkg::KIND_DONE;
                            res.last  = 1'b1;
                        end
                    end
                    PH_CMAP: begin
                        if (!count_one) begin
                            n_count = count_dec;
                        end else if (img_size != '0) begin
                            n_phase = PH_IMAGE;
                            n_count = img_size;
                        end else begin
                            n_phase   = PH_DONE;
                            n_count   = '0;
                            res_valid = 1'b1;
                            res.kind  = tsp_pkg::KIND_DONE;
                            res.last  = 1'b1;
                        end
                    end
                    PH_IMAGE: begin
                        n_count   = count_dec;
                        res_valid = 1'b1;
                        res.pixel = i_s_tdata;
                        if (count_one) begin
                            n_phase  = PH_DONE;
                            res.last = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= '0;
            r_count   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_count   <= n_count;
        end
    end

    tsp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (out_data),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {5'd0, out_data.height, out_data.width, out_data.status, out_data.pixel};
    assign o_m_tuser = out_data.kind;
    assign o_m_tlast = out_data.last;

`ifndef SYNTHESIS
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER || r_phase == PH_DONE) |-> (r_count == '0))
        else $error("count not clear outside a section");

    a_count_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ID || r_phase == PH_CMAP || r_phase == PH_IMAGE) |-> (r_count != '0))
        else $error("empty section left open");

    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_hdr_idx == '0))
        else $error("header index not rewound");

    a_eof_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> (r_phase == PH_HEADER))
        else $error("end of file did not re-arm");
`endif

endmodule
`default_nettype wire

[rtl/tsp_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// TGA stream parser output skid
// Output register plus one skid entry; ready to the parser is registered.
// ----------------------------------------------------------------------------
module tsp_skid (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  tsp_pkg::t_result i_data,
    output logic            o_ready,
    output logic            o_valid,
    output tsp_pkg::t_result o_data,
    input  wire             i_ready
);

    logic            r_out_valid;
    logic            r_skid_valid;
    tsp_pkg::t_result r_out;
    tsp_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (r_out_valid && !i_ready && i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire
